[sv/assert_macros.svh]
// Assertion macros shared by the frame builder RTL.
// No dependencies; expects signals clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/tfb_pkg.sv]
// Shared types, constants and the CRC-8 byte fold for the telemetry frame builder.
// No dependencies.
package tfb_pkg;

  // CRC-8/DVB-S2 polynomial
  localparam logic [7:0] CRC_POLY = 8'hD5;

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_SYNC    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_VERSION = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TYPE    = 2'd2;

  // Register reset values
  localparam logic [7:0] SYNC_RST    = 8'h00;
  localparam logic [7:0] VERSION_RST = 8'h01;
  localparam logic [7:0] TYPE_RST    = 8'h00;

  // Header byte values currently in force
  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] version_value;
    logic [7:0] type_value;
  } cfg_t;

  // Which byte of the frame the emitter is producing
  typedef enum logic [2:0] {
    PH_SYNC,
    PH_VER,
    PH_TYPE,
    PH_LEN,
    PH_DATA,
    PH_SEQ,
    PH_CRC
  } phase_t;

  // Fold one byte into the CRC, MSB first, no reflection
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[sv/telemetry_frame_builder_crc8.sv]
// Telemetry frame builder: wraps payload bytes into framed packets with CRC-8 trailer.
// Depends on tfb_pkg, tfb_cfg_regs and assert_macros.svh.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in      | input     | in_valid/in_ready   | in_data_byte
//  out     | output    | out_valid/out_ready | out_byte, out_run_last, out_frame_end
//  cfg     | input     | cfg_wr_en           | cfg_index, cfg_wdata
//
// An item sits in the input register while its bytes go into the output register, one
// byte per cycle while the output is not stalled: five bytes for the first item of a
// frame, one for a middle item, three for the last. The next item is taken in the cycle
// the held item's last byte moves out, so items follow back to back. Reset is synchronous;
// no clearing pass. A stalled output holds its byte and freezes the emitter; the input
// side stalls while the held item has bytes left to send or its last byte is held up.
module telemetry_frame_builder_crc8 #(
  parameter int PAYLOAD_BYTES = 58
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // payload byte input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  // framed byte output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_run_last,
  output logic                           out_frame_end,
  // configuration writes
  input  logic                           cfg_wr_en,
  input  logic [tfb_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_wdata
);
  import tfb_pkg::*;

  `include "assert_macros.svh"

  // Supplied bytes per frame; at least two so no item yields more than five bytes
  localparam int InputsPerFrame = (PAYLOAD_BYTES > 2) ? PAYLOAD_BYTES - 1 : 2;
  localparam int PosW = $clog2(InputsPerFrame);
  localparam logic [PosW-1:0] PosLast = PosW'(InputsPerFrame - 1);
  localparam logic [7:0] LenByte = 8'(PAYLOAD_BYTES);

  cfg_t cfg;

  logic           in_valid_r, in_valid_nxt;
  logic [7:0]     data_r;
  phase_t         phase_r, phase_nxt, phase_adv, start_phase;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [7:0]     crc_r, crc_nxt, crc_base, crc_folded;
  logic [7:0]     seq_r, seq_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_byte_r;
  logic           run_last_r, frame_end_r;

  logic           emit, load, item_done, frame_last;
  logic [7:0]     cur_byte;

  tfb_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  // Handshake: emit when a byte can enter the output register
  assign emit       = in_valid_r & (~out_valid_r | out_ready);
  assign in_ready   = ~in_valid_r | (emit & item_done);
  assign load       = in_valid & in_ready;
  assign frame_last = (pos_r == PosLast);

  // Next phase of the emitter
  always_comb begin
    phase_adv = PH_SYNC;
    item_done = 1'b0;
    unique case (phase_r)
      PH_SYNC: phase_adv = PH_VER;
      PH_VER:  phase_adv = PH_TYPE;
      PH_TYPE: phase_adv = PH_LEN;
      PH_LEN:  phase_adv = PH_DATA;
      PH_DATA: begin
        if (frame_last) begin
          phase_adv = PH_SEQ;
        end else begin
          item_done = 1'b1;
        end
      end
      PH_SEQ:  phase_adv = PH_CRC;
      PH_CRC:  item_done = 1'b1;
      default: item_done = 1'b1;
    endcase
  end

  // A new item starts with the header only at the top of a frame
  assign start_phase = (pos_nxt == '0) ? PH_SYNC : PH_DATA;

  always_comb begin
    if (load) begin
      phase_nxt = start_phase;
    end else if (emit) begin
      phase_nxt = phase_adv;
    end else begin
      phase_nxt = phase_r;
    end
  end

  // Byte select and frame state update
  always_comb begin
    cur_byte = data_r;
    pos_nxt  = pos_r;
    seq_nxt  = seq_r;
    crc_base = crc_r;
    unique case (phase_r)
      PH_SYNC: cur_byte = cfg.sync_value;
      PH_VER: begin
        cur_byte = cfg.version_value;
        crc_base = '0;
      end
      PH_TYPE: cur_byte = cfg.type_value;
      PH_LEN:  cur_byte = LenByte;
      PH_DATA: begin
        cur_byte = data_r;
        pos_nxt  = frame_last ? '0 : PosW'(pos_r + 1'b1);
      end
      PH_SEQ:  cur_byte = seq_r;
      PH_CRC: begin
        cur_byte = crc_r;
        seq_nxt  = 8'(seq_r + 8'd1);
      end
      default: cur_byte = data_r;
    endcase

    crc_folded = crc_fold(crc_base, cur_byte);
    // sync stays out of the CRC; the CRC byte restarts it
    if (phase_r == PH_SYNC) begin
      crc_nxt = crc_r;
    end else if (phase_r == PH_CRC) begin
      crc_nxt = '0;
    end else begin
      crc_nxt = crc_folded;
    end

    if (!emit) begin
      pos_nxt = pos_r;
      seq_nxt = seq_r;
      crc_nxt = crc_r;
    end
  end

  assign in_valid_nxt  = load | (in_valid_r & ~(emit & item_done));
  assign out_valid_nxt = emit | (out_valid_r & ~out_ready);

  // Control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_SYNC;
      pos_r       <= '0;
      crc_r       <= '0;
      seq_r       <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      seq_r       <= seq_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data_byte;
    end
    if (emit) begin
      out_byte_r  <= cur_byte;
      run_last_r  <= item_done;
      frame_end_r <= (phase_r == PH_CRC);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_run_last  = run_last_r;
  assign out_frame_end = frame_end_r;

  // Checks
  `ASSERT_CLK(a_crc_ends_item, out_valid && out_frame_end |-> out_run_last,
              "CRC byte is not the last byte of its item")
  `ASSERT_CLK(a_header_at_top, in_valid_r && (phase_r == PH_SYNC) |-> (pos_r == '0),
              "header started mid-frame")
  `ASSERT_CLK(a_seq_step, emit && (phase_r == PH_CRC) |=> (seq_r == 8'($past(seq_r) + 8'd1)),
              "sequence number did not advance after the CRC byte")

endmodule

[sv/tfb_cfg_regs.sv]
// Configuration register file for the frame header bytes.
// Depends on tfb_pkg.
module tfb_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [tfb_pkg::REG_IDX_W-1:0]  index,
  input  logic [7:0]                     wdata,
  output tfb_pkg::cfg_t                  cfg
);
  import tfb_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (index)
        REG_SYNC:    cfg_nxt.sync_value    = wdata;
        REG_VERSION: cfg_nxt.version_value = wdata;
        REG_TYPE:    cfg_nxt.type_value    = wdata;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_value    <= SYNC_RST;
      cfg_r.version_value <= VERSION_RST;
      cfg_r.type_value    <= TYPE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
